[sv/arwc_pkg.sv]
// shared constants, codes and types of the anti-replay window check
package arwc_pkg;

   localparam int unsigned WORD_BITS_DEFAULT = 64;
   localparam int unsigned WORDS_DEFAULT = 32;
   localparam logic [63:0] REJECT_LIMIT_RESET = 64'd18446744073709549630;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_LIMIT  = 2'd1,
      ST_OLD    = 2'd2,
      ST_DUP    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL_A,
      S_EVAL_B,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic eval_a;
      logic eval_b;
      logic commit;
   } cmd_type;

endpackage

[sv/arwc_ctrl.sv]
// sequencer for one nonce check and the result word handshake
module arwc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output arwc_pkg::cmd_type cmd
);
   import arwc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL_A;
            end
         end
         S_EVAL_A: begin
            cmd.eval_a = 1'b1;
            state_in   = S_EVAL_B;
         end
         S_EVAL_B: begin
            cmd.eval_b = 1'b1;
            state_in   = S_COMMIT;
         end
         S_COMMIT: begin
            // hold until the result register is free or being emptied
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[sv/arwc_dpath.sv]
// window state, bitmap ring and the compare logic of the nonce check
module arwc_dpath #(
   parameter int unsigned WORD_BITS = arwc_pkg::WORD_BITS_DEFAULT,
   parameter int unsigned WORDS     = arwc_pkg::WORDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  arwc_pkg::cmd_type   cmd,
   input  logic [63:0]         nonce,
   input  logic                cfg_wr,
   input  logic [63:0]         cfg_data,
   output arwc_pkg::status_type status
);
   import arwc_pkg::*;

   localparam int unsigned IDX_W       = $clog2(WORDS);
   localparam int unsigned DIST_W      = $clog2(WORDS) + 1;
   localparam int unsigned BIT_W       = $clog2(WORD_BITS);
   localparam int unsigned WINDOW_SIZE = (WORDS - 1) * WORD_BITS;

   logic [63:0]          nonce_ff, highest_ff, highest_in, limit_ff;
   logic                 limit_hit_ff, fwd_ff, old_ff;
   logic [DIST_W-1:0]    span_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic [WORDS-1:0]     valid_ff, valid_in;
   logic [WORD_BITS-1:0] seen_mem_ff [WORDS];
   status_type           status_ff, status_in;

   logic [63:0]          word_new, word_old, word_gap, nonce_gap;
   logic [IDX_W-1:0]     slot, old_slot;
   logic [BIT_W-1:0]     bit_idx;
   logic [WORDS-1:0]     clr_mask;
   logic [WORD_BITS-1:0] cur_word, set_word;
   logic                 dup, do_write;
   logic [DIST_W-1:0]    span_in;

   assign word_new  = nonce_ff / 64'(WORD_BITS);
   assign word_old  = highest_ff / 64'(WORD_BITS);
   assign slot      = IDX_W'(word_new % 64'(WORDS));
   assign old_slot  = IDX_W'(word_old % 64'(WORDS));
   assign bit_idx   = BIT_W'(nonce_ff % 64'(WORD_BITS));
   assign word_gap  = word_new - word_old;
   assign nonce_gap = highest_ff - nonce_ff;
   assign span_in   = (word_gap >= 64'(WORDS)) ? DIST_W'(WORDS) : word_gap[DIST_W-1:0];

   // ring distance of each word past the old top word, zero counts as a full turn
   always_comb begin
      logic [DIST_W-1:0] ring_ofs;
      for (int j = 0; j < WORDS; j++) begin
         if (IDX_W'(j) >= old_slot)
            ring_ofs = DIST_W'(j) - DIST_W'(old_slot);
         else
            ring_ofs = DIST_W'(j) + DIST_W'(WORDS) - DIST_W'(old_slot);
         if (ring_ofs == '0)
            ring_ofs = DIST_W'(WORDS);
         clr_mask[j] = fwd_ff && (ring_ofs <= span_ff);
      end
   end

   assign cur_word = clr_mask[slot] ? '0 : rd_word_ff;
   assign dup      = cur_word[bit_idx];
   assign set_word = cur_word | (WORD_BITS'(1) << bit_idx);

   always_comb begin
      status_in  = status_ff;
      highest_in = highest_ff;
      valid_in   = valid_ff;
      do_write   = 1'b0;
      if (cmd.commit) begin
         if (limit_hit_ff) begin
            status_in = ST_LIMIT;
         end else if (old_ff) begin
            status_in = ST_OLD;
         end else begin
            valid_in = valid_ff & ~clr_mask;
            if (fwd_ff)
               highest_in = nonce_ff;
            if (dup) begin
               status_in = ST_DUP;
            end else begin
               status_in      = ST_ACCEPT;
               valid_in[slot] = 1'b1;
               do_write       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         highest_ff <= '0;
         limit_ff   <= REJECT_LIMIT_RESET;
         valid_ff   <= '0;
      end else begin
         highest_ff <= highest_in;
         valid_ff   <= valid_in;
         if (cfg_wr)
            limit_ff <= cfg_data;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (cmd.load)
         nonce_ff <= nonce;
      if (cmd.eval_a) begin
         limit_hit_ff <= (highest_ff >= limit_ff) || (nonce_ff >= limit_ff);
         fwd_ff       <= nonce_ff > highest_ff;
      end
      if (cmd.eval_b) begin
         old_ff     <= !fwd_ff && (nonce_gap > 64'(WINDOW_SIZE));
         span_ff    <= span_in;
         rd_word_ff <= valid_ff[slot] ? seen_mem_ff[slot] : '0;
      end
      if (do_write)
         seen_mem_ff[slot] <= set_word;
   end

   assign status = status_ff;

endmodule

[sv/anti_replay_window_check_top.sv]
// top level of the anti-replay window check
//
// channel   direction  signals                      payload
// req       in         req_tvalid/tready/tdata      [63:0] nonce
// rsp       out        rsp_tvalid/tready/tdata      [1:0] status, [7:2] zero
// csr       in         csr_valid/ready/data         [63:0] reject_limit
//
// each nonce passes through these steps in order: accept, limit and forward compares, age compare
// with the bitmap word read, then commit into the result register
// the commit waits while an earlier result word is still held by rsp_tready
// synchronous reset clears the top nonce and the word valid bits and reloads the reset limit
// csr writes are always taken and belong between checks
module anti_replay_window_check_top #(
   parameter int unsigned WORD_BITS = arwc_pkg::WORD_BITS_DEFAULT,
   parameter int unsigned WORDS     = arwc_pkg::WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] nonce
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] status, [7:2] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data     // [63:0] reject_limit
);
   import arwc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   arwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   arwc_dpath #(
      .WORD_BITS (WORD_BITS),
      .WORDS     (WORDS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .nonce    (req_tdata),
      .cfg_wr   (csr_valid && csr_ready),
      .cfg_data (csr_data),
      .status   (status)
   );

   assign rsp_tdata = {6'b0, status};

endmodule

[verif/window_checker.sv]
// scoreboard for the anti-replay window check: predicts each status word and compares
`timescale 1ns / 1ps
module window_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] nonce
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [1:0] status, [7:2] zero
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [63:0] csr_data,    // [63:0] reject_limit
   output int          fail_count,
   output int          pending,
   output int          n_checked,
   output int          n_accept,
   output int          n_limit,
   output int          n_old,
   output int          n_dup
);
   import arwc_pkg::*;

   localparam int unsigned WORD_BITS = WORD_BITS_DEFAULT;
   localparam int unsigned WORDS     = WORDS_DEFAULT;
   localparam int unsigned WINDOW    = (WORDS - 1) * WORD_BITS;
   localparam int          MAX_LINES = 20;

   logic [63:0] limit_reg;
   logic [63:0] top_seen;
   logic [63:0] bitmap [WORDS];
   status_type  status_due [$];

   function automatic status_type window_verdict(input logic [63:0] nonce);
      logic [63:0] word_new;
      logic [63:0] word_old;
      logic [63:0] span;
      logic [63:0] mask;
      logic [63:0] i;
      int unsigned slot;
      if (top_seen >= limit_reg || nonce >= limit_reg) return ST_LIMIT;
      // difference form, no wrap
      if (nonce < top_seen && top_seen - nonce > WINDOW) return ST_OLD;
      word_new = nonce / WORD_BITS;
      word_old = top_seen / WORD_BITS;
      if (nonce > top_seen) begin
         span = word_new - word_old;
         if (span > WORDS) span = 64'(WORDS);
         // clear the ring words skipped by the forward move
         for (i = 1; i <= span; i++) begin
            bitmap[(word_old + i) % WORDS] = '0;
         end
         top_seen = nonce;
      end
      slot = 32'(word_new % WORDS);
      mask = 64'd1 << (nonce % WORD_BITS);
      if ((bitmap[slot] & mask) != 0) return ST_DUP;
      bitmap[slot] = bitmap[slot] | mask;
      return ST_ACCEPT;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < MAX_LINES) begin
         $display("MISMATCH at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin : scoreboard
      status_type want;
      if (reset) begin
         limit_reg = REJECT_LIMIT_RESET;
         top_seen = '0;
         for (int w = 0; w < WORDS; w++) begin
            bitmap[w] = '0;
         end
         status_due.delete();
         fail_count = 0;
         n_checked = 0;
         n_accept = 0;
         n_limit = 0;
         n_old = 0;
         n_dup = 0;
      end else begin
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_tvalid && req_tready) status_due.push_back(window_verdict(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               report_mismatch("status word with no nonce waiting", 64'(rsp_tdata), 64'(0));
            end else begin
               want = status_due.pop_front();
               n_checked++;
               case (want)
                  ST_ACCEPT: n_accept++;
                  ST_LIMIT:  n_limit++;
                  ST_OLD:    n_old++;
                  default:   n_dup++;
               endcase
               if (rsp_tdata[1:0] != want) begin
                  report_mismatch("status", 64'(rsp_tdata[1:0]), 64'(want));
               end
               if (rsp_tdata[7:2] != '0) begin
                  report_mismatch("padding bits", 64'(rsp_tdata[7:2]), 64'(0));
               end
            end
         end
      end
      pending = status_due.size();
   end

endmodule

[verif/tb_top.sv]
// testbench top: drives nonces, limit writes and result back-pressure, gives the verdict
`timescale 1ns / 1ps
module tb_top;
   import arwc_pkg::*;

   localparam int unsigned WINDOW      = (WORDS_DEFAULT - 1) * WORD_BITS_DEFAULT;
   localparam int          CYCLE_LIMIT = 800000;
   localparam int          HOLD_CYCLES = 300;
   localparam int          BURST_ITEMS = 40;
   localparam int          SETTLE      = 8;
   localparam logic [63:0] ALL_ONES    = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_data = '0;

   int fail_count;
   int pending;
   int n_checked;
   int n_accept;
   int n_limit;
   int n_old;
   int n_dup;

   int cycle_count = 0;
   int hold_requests = 0;
   int items_sent = 0;
   int limit_writes = 0;
   logic no_idle = 1'b0;
   logic rx_calm = 1'b0;

   // stimulus-side view of the window, used to aim the random nonces and to pick limit values
   logic [63:0] cur_limit = REJECT_LIMIT_RESET;
   logic [63:0] top_nonce = '0;
   logic [63:0] recent [16];
   int          recent_pos = 0;

   always #5 clock = ~clock;

   anti_replay_window_check_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   window_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .n_checked  (n_checked),
      .n_accept   (n_accept),
      .n_limit    (n_limit),
      .n_old      (n_old),
      .n_dup      (n_dup)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (no_idle) return 0;
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] random_nonce();
      int roll;
      roll = $urandom_range(99);
      if (roll < 38) return top_nonce + $urandom_range(0, 80);
      if (roll < 52) return top_nonce + $urandom_range(64, 4200);
      if (roll < 67) return top_nonce - $urandom_range(0, WINDOW);
      // right at the window edge
      if (roll < 73) return top_nonce - (WINDOW - 1 + $urandom_range(0, 2));
      if (roll < 80) return top_nonce - $urandom_range(WINDOW + 1, 9000);
      if (roll < 91) return recent[$urandom_range(0, 15)];
      if (roll < 98) return cur_limit - 3 + $urandom_range(0, 6);
      return {$urandom, $urandom};
   endfunction

   // entered and left at a falling edge; tvalid stays high when the next word follows at once
   task automatic send_nonce(input logic [63:0] nonce);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = nonce;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (top_nonce < cur_limit && nonce < cur_limit && nonce > top_nonce) top_nonce = nonce;
      recent[recent_pos] = nonce;
      recent_pos = (recent_pos + 1) % 16;
      items_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_limit(input logic [63:0] value);
      wait_drain();
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      cur_limit = value;
      limit_writes++;
   endtask

   task automatic run_random(input int count, input int hold_at, input int calm_at);
      int burst_left;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) begin
            hold_requests++;
            burst_left = BURST_ITEMS;
         end
         rx_calm = (i >= calm_at && i < calm_at + 60);
         no_idle = (burst_left > 0) || rx_calm;
         if (burst_left > 0) burst_left--;
         if ($urandom_range(199) == 0) wait_drain();
         send_nonce(random_nonce());
      end
      no_idle = 1'b0;
      rx_calm = 1'b0;
   endtask

   // result side: random back-pressure plus the long hold-offs asked for
   initial begin : result_sink
      int hold_served;
      int roll;
      hold_served = 0;
      forever begin
         roll = $urandom_range(99);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (rx_calm || roll < 60) begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else if (roll < 95) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [63:0] lim;
      for (int k = 0; k < 16; k++) begin
         recent[k] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: window basics at the reset limit
      send_nonce(64'd0);
      send_nonce(64'd0);                      // duplicate at the highest
      send_nonce(64'd1);
      send_nonce(64'd63);
      send_nonce(64'd64);                     // next ring word
      send_nonce(64'd2048);                   // forward move over many words
      send_nonce(64'd64);                     // oldest word kept, duplicate
      send_nonce(64'd63);                     // one past the window
      send_nonce(64'd5000);                   // skip wider than the ring
      send_nonce(64'd5000 - WINDOW);          // exactly at the window edge
      send_nonce(64'd5000 - WINDOW - 1);      // too old
      send_nonce(ALL_ONES);
      send_nonce(REJECT_LIMIT_RESET);
      send_nonce(REJECT_LIMIT_RESET - 1 - 64'd1 - 64'd5000 + 64'd5000 - REJECT_LIMIT_RESET
                 + 64'd4999);                 // in window below the highest
      write_limit(64'd0);
      send_nonce(64'd0);
      send_nonce(64'd5001);
      write_limit(64'd5001);
      send_nonce(64'd5001);
      send_nonce(64'd5000);
      write_limit(64'd5000);                  // highest has reached the limit
      send_nonce(64'd10);
      send_nonce(64'd4990);
      write_limit(ALL_ONES);
      send_nonce(64'd5001);

      run_random(500, 100, 300);

      lim = top_nonce + $urandom_range(500, 20000);
      if (lim < top_nonce) lim = ALL_ONES;
      write_limit(lim);
      run_random(500, 250, 50);

      write_limit(top_nonce);
      run_random(20, -1, -1);

      write_limit(ALL_ONES);
      run_random(460, 200, 380);

      // top of the nonce range
      send_nonce(ALL_ONES - 1);
      send_nonce(ALL_ONES);
      send_nonce(ALL_ONES - 1);
      send_nonce(ALL_ONES - 2);
      send_nonce(ALL_ONES - 1 - WINDOW);
      send_nonce(ALL_ONES - 2 - WINDOW);

      wait_drain();
      repeat (20) @(negedge clock);
      $display("covered %0d nonces over %0d limit settings and %0d long result hold-offs",
               items_sent, limit_writes, hold_requests);
      $display("status words checked %0d: accepted %0d, over limit %0d, too old %0d, dup %0d",
               n_checked, n_accept, n_limit, n_old, n_dup);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[anti_replay_window_check_top.f]
sv/arwc_pkg.sv
sv/arwc_ctrl.sv
sv/arwc_dpath.sv
sv/anti_replay_window_check_top.sv
verif/window_checker.sv
verif/tb_top.sv
